FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the PID controller.
// Depends on nothing; the asserting module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while reset is low.
`define PIDCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pidcc: assertion failed");

// Checked at every edge, reset included.
`define PIDCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pidcc: assertion failed");

`else

`define PIDCC_ASSERT(lbl, prop)
`define PIDCC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: rtl/pidcc_pkg.sv
// Constants and register indexes of the PID controller.
// No dependencies.
package pidcc_pkg;

  localparam int GAIN_W       = 31;
  localparam int COEF_W       = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int ISUM_W       = 48;
  localparam int MUL_G_W      = 32;
  localparam int MRES_W       = 64;
  localparam int TERM_W       = 32;
  localparam int PROD_LIM_EXP = 62;

  localparam logic [COEF_W-1:0] COEF_RESET = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_I_LIMIT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_D_LIMIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd7;

  localparam logic REQ_UPDATE  = 1'b0;
  localparam logic REQ_PRELOAD = 1'b1;

endpackage

FILE: rtl/pidcc_if.sv
// Handshake channels of the PID controller: request, response, register write.
// Depends on pidcc_pkg.
interface pidcc_req_if #(parameter int DATA_WIDTH = 32);
  import pidcc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] position;
  logic signed [DATA_WIDTH-1:0] integral_preload;
  modport source (output valid, req_type, setpoint, position, integral_preload,
                  input ready);
  modport sink (input valid, req_type, setpoint, position, integral_preload,
                output ready);
endinterface

interface pidcc_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] control_out;
  logic signed [DATA_WIDTH-1:0] p_term;
  logic signed [DATA_WIDTH-1:0] i_term;
  logic signed [DATA_WIDTH-1:0] d_term;
  modport source (output valid, control_out, p_term, i_term, d_term, input ready);
  modport sink (input valid, control_out, p_term, i_term, d_term, output ready);
endinterface

interface pidcc_cfg_if;
  import pidcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/pid_controller_clamped_terms.sv
// PID controller with clamped terms and back-calculation anti-windup.
// An update word runs five products on the shared shift-add multiplier: proportional,
// integral, derivative gain times filter coefficient, derivative and filter. A zero integral
// gain skips the integral product, a zero derivative gain the two derivative products, and
// a clamped integral term adds a pass of the one-bit-per-cycle restoring divider. A preload
// runs only the divider, or neither unit with a zero integral gain. The next word is
// accepted in the cycle after the result loads. Reset (rst, synchronous) clears the integral
// and derivative state, the gains and limits, and sets the filter coefficient to one.
module pid_controller_clamped_terms #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  pidcc_cfg_if.sink   cfg,
  pidcc_req_if.sink   req,
  pidcc_rsp_if.source rsp
);
  import pidcc_pkg::*;

  `include "assert_macros.svh"

  // Widths. The error needs one bit over the data, the derivative difference two.
  localparam int D     = DATA_WIDTH;
  localparam int EW    = D + 1;
  localparam int DFW   = D + 2;
  localparam int DSW   = D + 1;
  localparam int MX    = (ISUM_W > DFW) ? ISUM_W : DFW;
  localparam int PW    = MUL_G_W + MX;
  localparam int QW    = PW - FRAC_BITS;
  localparam int QEW   = (QW > MRES_W) ? QW : MRES_W;
  localparam int TMW   = (D > TERM_W) ? D : TERM_W;
  localparam int DVW   = TMW + FRAC_BITS;
  localparam int DVC_W = $clog2(DVW);
  localparam int MC_W  = $clog2(MUL_G_W);
  localparam int ISW   = ((ISUM_W > EW) ? ISUM_W : EW) + 1;
  localparam int QXW   = ((DVW > ISUM_W) ? DVW : ISUM_W) + 1;
  localparam int DSA   = MRES_W + 1;

  localparam logic signed [ISW-1:0] IS_HI = {{(ISW-ISUM_W+1){1'b0}}, {(ISUM_W-1){1'b1}}};
  localparam logic signed [ISW-1:0] IS_LO = ~IS_HI;
  localparam logic signed [DSA-1:0] DS_HI = {{(DSA-DSW+1){1'b0}}, {(DSW-1){1'b1}}};
  localparam logic signed [DSA-1:0] DS_LO = ~DS_HI;
  localparam logic [QXW-1:0] DQ_MAG = {{(QXW-ISUM_W){1'b0}}, 1'b1, {(ISUM_W-1){1'b0}}};
  localparam logic [QXW-1:0] DQ_HI  = DQ_MAG - 1'b1;
  localparam logic [QEW-1:0] MQ_LIM = QEW'(1) << PROD_LIM_EXP;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_PLD   = 4'd2;
  localparam logic [3:0] S_PFIN  = 4'd3;
  localparam logic [3:0] S_IFIN  = 4'd4;
  localparam logic [3:0] S_KLD   = 4'd5;
  localparam logic [3:0] S_KFIN  = 4'd6;
  localparam logic [3:0] S_DFIN  = 4'd7;
  localparam logic [3:0] S_FLD   = 4'd8;
  localparam logic [3:0] S_FFIN  = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_PRE   = 4'd12;
  localparam logic [3:0] S_MRUN  = 4'd13;
  localparam logic [3:0] S_DRUN  = 4'd14;
  localparam logic [3:0] S_DVFIN = 4'd15;

  // Symmetric clamp of a wide signed value to a 31-bit limit.
  function automatic logic signed [TERM_W-1:0] clamp_sym(
    input logic signed [MRES_W-1:0] x, input logic [GAIN_W-1:0] lim);
    logic signed [MRES_W-1:0] l;
    logic signed [MRES_W-1:0] r;
    l = signed'(MRES_W'(lim));
    if (x > l) begin
      r = l;
    end else if (x < -l) begin
      r = -l;
    end else begin
      r = x;
    end
    return TERM_W'(r);
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0] p_gain, i_gain, d_gain, p_limit, i_limit, d_limit, out_limit;
  logic [COEF_W-1:0] filter_coef;
  logic [COEF_W-1:0] f_eff;

  // Sequencer and item state.
  logic [3:0]                state;
  logic [3:0]                mul_ret;
  logic                      is_pre;
  logic signed [D-1:0]       sp, pos, pre;
  logic signed [EW-1:0]      err;
  logic signed [DFW-1:0]     diff;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [DSW-1:0]     ds;
  logic signed [TERM_W-1:0]  p_t, i_t, d_t, co_t;

  // Shift-add multiplier: the gain sits in the low MUL_G_W bits and is consumed one
  // bit per cycle while the magnitude is added into the upper bits.
  logic [PW-1:0]             mul_prod;
  logic [MX-1:0]             mul_m;
  logic                      mul_neg;
  logic [MC_W-1:0]           mul_cnt;
  logic [MX:0]               msum;
  logic [QEW-1:0]            mqx;
  logic [MRES_W-1:0]         mqs;
  logic                      mr;
  logic signed [MRES_W-1:0]  mres;

  logic                      mul_load;
  logic [MUL_G_W-1:0]        ld_g;
  logic signed [MX-1:0]      ld_x;
  logic [MX-1:0]             ld_m;
  logic [3:0]                ld_ret;

  // Restoring divider: one quotient bit per cycle.
  logic [DVW-1:0]            dv_n;
  logic [GAIN_W-1:0]         dv_rem;
  logic [GAIN_W-1:0]         dv_g;
  logic                      dv_neg;
  logic [DVC_W-1:0]          dv_cnt;
  logic [GAIN_W:0]           dv_rs;
  logic                      dv_ge;
  logic [QXW-1:0]            dv_qx;
  logic signed [ISUM_W-1:0]  dvres;
  logic                      dv_load;
  logic signed [TMW-1:0]     dv_t;
  logic [TMW-1:0]            dv_m;

  logic signed [ISW-1:0]     isum_add;
  logic signed [ISUM_W-1:0]  isum_sat;
  logic signed [DSA-1:0]     ds_add;
  logic signed [DSW-1:0]     ds_sat;
  logic signed [TERM_W-1:0]  i_cl;
  logic                      i_clipped;

  logic                      out_valid;
  logic signed [D-1:0]       out_co, out_p, out_i, out_d;

  assign cfg.ready       = 1'b1;
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.control_out = out_co;
  assign rsp.p_term      = out_p;
  assign rsp.i_term      = out_i;
  assign rsp.d_term      = out_d;

  // A filter coefficient above one acts as one.
  assign f_eff = (32'(filter_coef) > (32'd1 << FRAC_BITS)) ?
                 COEF_W'(32'd1 << FRAC_BITS) : filter_coef;

  // Multiplier step and result: floor shift, saturate near 2^62, and round
  // the negative magnitude away from zero when any fraction bit was lost.
  always_comb begin
    msum = {1'b0, mul_prod[PW-1:MUL_G_W]} + (mul_prod[0] ? {1'b0, mul_m} : '0);
    mqx  = QEW'(mul_prod[PW-1:FRAC_BITS]);
    mqs  = (mqx > MQ_LIM) ? MRES_W'(MQ_LIM) : MRES_W'(mqx);
    mr   = |mul_prod[FRAC_BITS-1:0];
    mres = mul_neg ? -(signed'(mqs) + signed'(MRES_W'(mr))) : signed'(mqs);
  end

  // Divider step and saturation of the quotient into the integral width.
  always_comb begin
    dv_rs = {dv_rem, dv_n[DVW-1]};
    dv_ge = (dv_rs >= {1'b0, dv_g});
    dv_qx = QXW'(dv_n);
    if (dv_neg) begin
      dvres = (dv_qx > DQ_MAG) ? signed'(ISUM_W'(~IS_HI)) : signed'(ISUM_W'(~dv_qx + 1'b1));
    end else begin
      dvres = (dv_qx > DQ_HI) ? signed'(ISUM_W'(IS_HI)) : signed'(ISUM_W'(dv_qx));
    end
  end

  // State updates with saturation.
  always_comb begin
    isum_add = ISW'(isum) + ISW'(err);
    if (isum_add > IS_HI) begin
      isum_sat = ISUM_W'(IS_HI);
    end else if (isum_add < IS_LO) begin
      isum_sat = ISUM_W'(IS_LO);
    end else begin
      isum_sat = ISUM_W'(isum_add);
    end
    ds_add = DSA'(ds) + DSA'(mres);
    if (ds_add > DS_HI) begin
      ds_sat = DSW'(DS_HI);
    end else if (ds_add < DS_LO) begin
      ds_sat = DSW'(DS_LO);
    end else begin
      ds_sat = DSW'(ds_add);
    end
    i_cl      = clamp_sym(mres, i_limit);
    i_clipped = (MRES_W'(i_cl) != mres);
  end

  // Operand selection for the shared multiplier and the divider.
  always_comb begin
    mul_load = 1'b0;
    ld_g     = '0;
    ld_x     = '0;
    ld_ret   = S_IDLE;
    dv_load  = 1'b0;
    dv_t     = '0;
    unique case (state)
      S_PLD: begin
        mul_load = 1'b1;
        ld_g     = MUL_G_W'(p_gain);
        ld_x     = MX'(err);
        ld_ret   = S_PFIN;
      end
      S_PFIN: begin
        mul_load = (i_gain != '0);
        ld_g     = MUL_G_W'(i_gain);
        ld_x     = MX'(isum);
        ld_ret   = S_IFIN;
      end
      S_IFIN: begin
        dv_load = i_clipped;
        dv_t    = TMW'(i_cl);
      end
      S_KLD: begin
        mul_load = (d_gain != '0);
        ld_g     = MUL_G_W'(d_gain);
        ld_x     = signed'(MX'(f_eff));
        ld_ret   = S_KFIN;
      end
      S_KFIN: begin
        mul_load = 1'b1;
        ld_g     = mres[MUL_G_W-1:0];
        ld_x     = MX'(diff);
        ld_ret   = S_DFIN;
      end
      S_FLD: begin
        mul_load = 1'b1;
        ld_g     = MUL_G_W'(f_eff);
        ld_x     = MX'(diff);
        ld_ret   = S_FFIN;
      end
      S_PRE: begin
        dv_load = (i_gain != '0);
        dv_t    = TMW'(pre);
      end
      default: begin
      end
    endcase
    ld_m = ld_x[MX-1] ? (~ld_x + 1'b1) : ld_x;
    dv_m = dv_t[TMW-1] ? (~dv_t + 1'b1) : dv_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      isum        <= '0;
      ds          <= '0;
      p_gain      <= '0;
      i_gain      <= '0;
      d_gain      <= '0;
      filter_coef <= COEF_RESET;
      p_limit     <= '0;
      i_limit     <= '0;
      d_limit     <= '0;
      out_limit   <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_P_GAIN:      p_gain      <= cfg.data[GAIN_W-1:0];
          REG_I_GAIN:      i_gain      <= cfg.data[GAIN_W-1:0];
          REG_D_GAIN:      d_gain      <= cfg.data[GAIN_W-1:0];
          REG_FILTER_COEF: filter_coef <= cfg.data[COEF_W-1:0];
          REG_P_LIMIT:     p_limit     <= cfg.data[GAIN_W-1:0];
          REG_I_LIMIT:     i_limit     <= cfg.data[GAIN_W-1:0];
          REG_D_LIMIT:     d_limit     <= cfg.data[GAIN_W-1:0];
          REG_OUT_LIMIT:   out_limit   <= cfg.data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end

      // A word taken by the receiver empties the output register, unless the
      // sequencer refills it in the same cycle.
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      if (mul_load) begin
        mul_prod <= {{MX{1'b0}}, ld_g};
        mul_m    <= ld_m;
        mul_neg  <= ld_x[MX-1];
        mul_cnt  <= '0;
        mul_ret  <= ld_ret;
      end

      if (dv_load) begin
        dv_n   <= {dv_m, {FRAC_BITS{1'b0}}};
        dv_rem <= '0;
        dv_g   <= i_gain;
        dv_neg <= dv_t[TMW-1];
        dv_cnt <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            sp     <= req.setpoint;
            pos    <= req.position;
            pre    <= req.integral_preload;
            is_pre <= (req.req_type == REQ_PRELOAD);
            state  <= (req.req_type == REQ_PRELOAD) ? S_PRE : S_ERR;
          end
        end
        S_ERR: begin
          err   <= EW'(sp) - EW'(pos);
          diff  <= -DFW'(pos) - DFW'(ds);
          state <= S_PLD;
        end
        S_PLD: begin
          isum  <= isum_sat;
          state <= S_MRUN;
        end
        S_MRUN: begin
          mul_prod <= {msum, mul_prod[MUL_G_W-1:1]};
          mul_cnt  <= mul_cnt + 1'b1;
          if (mul_cnt == MC_W'(MUL_G_W - 1)) begin
            state <= mul_ret;
          end
        end
        S_PFIN: begin
          p_t <= clamp_sym(mres, p_limit);
          if (i_gain != '0) begin
            state <= S_MRUN;
          end else begin
            i_t   <= '0;
            state <= S_KLD;
          end
        end
        S_IFIN: begin
          i_t   <= i_cl;
          // Back-calculation: a clamped term resets the sum to term / gain.
          state <= i_clipped ? S_DRUN : S_KLD;
        end
        S_DRUN: begin
          dv_rem <= dv_ge ? GAIN_W'(dv_rs - {1'b0, dv_g}) : GAIN_W'(dv_rs);
          dv_n   <= {dv_n[DVW-2:0], dv_ge};
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_cnt == DVC_W'(DVW - 1)) begin
            state <= S_DVFIN;
          end
        end
        S_DVFIN: begin
          isum  <= dvres;
          state <= is_pre ? S_DONE : S_KLD;
        end
        S_KLD: begin
          if (d_gain != '0) begin
            state <= S_MRUN;
          end else begin
            d_t   <= '0;
            state <= S_FLD;
          end
        end
        S_KFIN: begin
          state <= S_MRUN;
        end
        S_DFIN: begin
          d_t   <= clamp_sym(mres, d_limit);
          state <= S_FLD;
        end
        S_FLD: begin
          state <= S_MRUN;
        end
        S_FFIN: begin
          ds    <= ds_sat;
          state <= S_SUM;
        end
        S_SUM: begin
          co_t  <= clamp_sym(MRES_W'(p_t) + MRES_W'(i_t) + MRES_W'(d_t), out_limit);
          state <= S_DONE;
        end
        S_PRE: begin
          // Align the derivative state to the position; all terms read zero.
          ds    <= -DSW'(pos);
          p_t   <= '0;
          i_t   <= '0;
          d_t   <= '0;
          co_t  <= '0;
          state <= (i_gain != '0) ? S_DRUN : S_DONE;
        end
        S_DONE: begin
          // The output register frees the sequencer once the word is loaded.
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_co    <= D'(co_t);
            out_p     <= D'(p_t);
            out_i     <= D'(i_t);
            out_d     <= D'(d_t);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PIDCC_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == S_IDLE && !out_valid))
  `PIDCC_ASSERT(a_mul_return,
    (state == S_MRUN && mul_cnt == MC_W'(MUL_G_W - 1)) |=> (state == $past(mul_ret)))
  `PIDCC_ASSERT(a_rsp_from_done, $rose(out_valid) |-> ($past(state) == S_DONE))
  `PIDCC_ASSERT(a_idle_state_kept, (state == S_IDLE) |=> ($stable(isum) && $stable(ds)))

endmodule
